/* rtl/core/mqlf_pkg.sv */
// Package: sizes, codes and field layout of the multi-queue linked FIFO.
`default_nettype none

package mqlf_pkg;

  localparam int unsigned NUM_QUEUES = 3;
  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned QSEL_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_BITS    = OPCODE_W + QSEL_W + VALUE_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = STATUS_W + VALUE_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_QUEUE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/multi_queue_linked_fifo.sv */
// Several FIFO queues sharing one linked entry store. Each request is a push or
// a pop on one queue and gives one response with a status and the popped value.
// In the accept cycle a request reads the link and value stores (synchronous
// RAMs) at the queue head or the free-list top; in the execute state it updates
// pointers, writes the stores back and loads the response register. A new
// request is taken while an earlier response still waits; the execute step then
// stalls until that response leaves the register. No clearing pass after reset:
// entries are handed out in order first, then recycled from a LIFO free list.
`default_nettype none

module multi_queue_linked_fifo
  import mqlf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [0] opcode, [2:1] queue_select, [34:3] push_value, rest zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [1:0] status, [33:2] popped_value, rest zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e state_q, state_d;

  // request fields
  logic [OPCODE_W-1:0]      in_op;
  logic [QSEL_W-1:0]        in_q;
  logic signed [VALUE_W-1:0] in_val;

  logic [OPCODE_W-1:0]      op_q, op_d;
  logic [QSEL_W-1:0]        qsel_q, qsel_d;
  logic [VALUE_W-1:0]       val_q, val_d;

  // queue pointers
  logic [ADDR_W-1:0] head_q [NUM_QUEUES];
  logic [ADDR_W-1:0] head_d [NUM_QUEUES];
  logic [ADDR_W-1:0] tail_q [NUM_QUEUES];
  logic [ADDR_W-1:0] tail_d [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty_q, nonempty_d;

  logic [CNT_W-1:0]  fresh_q, fresh_d;
  logic [ADDR_W-1:0] free_head_q, free_head_d;
  logic [CNT_W-1:0]  free_cnt_q, free_cnt_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0]  popped_q, popped_d;

  // stores
  logic [DATA_WIDTH-1:0] value_mem [ENTRIES];
  logic [ADDR_W-1:0]     next_mem  [ENTRIES];
  logic [DATA_WIDTH-1:0] value_rd_q;
  logic [ADDR_W-1:0]     next_rd_q;

  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  val_we;
  logic [ADDR_W-1:0]     val_waddr;
  logic [DATA_WIDTH-1:0] val_wdata;
  logic                  nxt_we;
  logic [ADDR_W-1:0]     nxt_waddr;
  logic [ADDR_W-1:0]     nxt_wdata;

  logic              in_fire;
  logic              exec_fire;
  logic              in_q_ok;
  logic [QIDX_W-1:0] in_qi;
  logic              ex_q_ok;
  logic [QIDX_W-1:0] ex_qi;
  logic [ADDR_W-1:0] ex_head;
  logic [ADDR_W-1:0] ex_tail;
  logic              ex_nonempty;
  logic [ADDR_W-1:0] new_e;
  logic signed [63:0] popped_wide;

  assign in_op  = s_axis_tdata_i[0];
  assign in_q   = s_axis_tdata_i[QSEL_W:1];
  assign in_val = s_axis_tdata_i[IN_BITS-1:OPCODE_W+QSEL_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready_i);

  assign in_q_ok = ({1'b0, in_q} < (QSEL_W + 1)'(NUM_QUEUES));
  assign in_qi   = in_q_ok ? QIDX_W'(in_q) : '0;
  assign ex_q_ok = ({1'b0, qsel_q} < (QSEL_W + 1)'(NUM_QUEUES));
  assign ex_qi   = ex_q_ok ? QIDX_W'(qsel_q) : '0;

  assign ex_head     = head_q[ex_qi];
  assign ex_tail     = tail_q[ex_qi];
  assign ex_nonempty = nonempty_q[ex_qi];

  // pop reads at the queue head, push reads the free-list link
  assign rd_en   = in_fire;
  assign rd_addr = (in_op == OP_POP) ? head_q[in_qi] : free_head_q;

  assign popped_wide = 64'(signed'(value_rd_q));

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    qsel_d      = qsel_q;
    val_d       = val_q;
    head_d      = head_q;
    tail_d      = tail_q;
    nonempty_d  = nonempty_q;
    fresh_d     = fresh_q;
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    status_d    = status_q;
    popped_d    = popped_q;
    val_we      = 1'b0;
    val_waddr   = '0;
    val_wdata   = '0;
    nxt_we      = 1'b0;
    nxt_waddr   = '0;
    nxt_wdata   = '0;
    new_e       = '0;

    if (in_fire) begin
      op_d    = in_op;
      qsel_d  = in_q;
      val_d   = in_val;
      state_d = S_EXEC;
    end

    if (exec_fire) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      popped_d    = '0;
      if (!ex_q_ok) begin
        status_d = ST_BAD_QUEUE;
      end else if (op_q == OP_PUSH) begin
        priority if (fresh_q < CNT_W'(ENTRIES)) begin
          new_e   = fresh_q[ADDR_W-1:0];
          fresh_d = fresh_q + 1'b1;
        end else if (free_cnt_q != '0) begin
          new_e       = free_head_q;
          free_head_d = next_rd_q;
          free_cnt_d  = free_cnt_q - 1'b1;
        end else begin
          status_d = ST_FULL;
        end
        if (status_d == ST_OK) begin
          val_we    = 1'b1;
          val_waddr = new_e;
          val_wdata = DATA_WIDTH'(val_q);
          tail_d[ex_qi] = new_e;
          if (ex_nonempty) begin
            nxt_we    = 1'b1;
            nxt_waddr = ex_tail;
            nxt_wdata = new_e;
          end else begin
            head_d[ex_qi]     = new_e;
            nonempty_d[ex_qi] = 1'b1;
          end
        end
      end else begin
        if (!ex_nonempty) begin
          status_d = ST_EMPTY;
        end else begin
          popped_d = popped_wide[VALUE_W-1:0];
          if (ex_head == ex_tail) begin
            nonempty_d[ex_qi] = 1'b0;
          end else begin
            head_d[ex_qi] = next_rd_q;
          end
          // old head goes on top of the free list
          nxt_we      = 1'b1;
          nxt_waddr   = ex_head;
          nxt_wdata   = free_head_q;
          free_head_d = ex_head;
          free_cnt_d  = free_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_PUSH;
      qsel_q      <= '0;
      val_q       <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      nonempty_q  <= '0;
      fresh_q     <= '0;
      free_head_q <= '0;
      free_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      popped_q    <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      qsel_q      <= qsel_d;
      val_q       <= val_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      nonempty_q  <= nonempty_d;
      fresh_q     <= fresh_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      popped_q    <= popped_d;
    end
  end

  // value store
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      value_mem[val_waddr] <= val_wdata;
    end
    if (rd_en) begin
      value_rd_q <= value_mem[rd_addr];
    end
  end

  // link store
  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      next_mem[nxt_waddr] <= nxt_wdata;
    end
    if (rd_en) begin
      next_rd_q <= next_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({popped_q, status_q});

endmodule

`default_nettype wire

/* bench/mqlf_checker.sv */
// Checker for the multi-queue linked FIFO: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module mqlf_checker
  import mqlf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  input  logic                   s_ready_i,
  // [0] opcode, [2:1] queue_select, [34:3] push_value, rest zero
  input  logic [IN_TDATA_W-1:0]  s_data_i,
  input  logic                   m_valid_i,
  input  logic                   m_ready_i,
  // [1:0] status, [33:2] popped_value, rest zero
  input  logic [OUT_TDATA_W-1:0] m_data_i,
  output int unsigned            pending_o,
  output int unsigned            fail_count_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } queue_resp_t;

  // mirror of the block's queues and linked store
  logic [ADDR_W-1:0]     head_ptr  [NUM_QUEUES];
  logic [ADDR_W-1:0]     tail_ptr  [NUM_QUEUES];
  logic                  q_live    [NUM_QUEUES];
  logic [DATA_WIDTH-1:0] cell_val  [ENTRIES];
  logic [ADDR_W-1:0]     cell_link [ENTRIES];
  int unsigned           fresh_used;
  int unsigned           recycle_cnt;
  logic [ADDR_W-1:0]     recycle_top;

  queue_resp_t owed_responses[$];
  queue_resp_t owed;
  queue_resp_t seen;

  function automatic queue_resp_t predict_queue_op(input logic [OPCODE_W-1:0] op,
                                                   input logic [QSEL_W-1:0]   q,
                                                   input logic [VALUE_W-1:0]  v);
    queue_resp_t       r;
    logic [ADDR_W-1:0] e;
    logic [ADDR_W-1:0] h;
    r.status = ST_OK;
    r.value  = '0;
    e        = '0;
    if (q >= NUM_QUEUES) begin
      r.status = ST_BAD_QUEUE;
    end else if (op == OP_PUSH) begin
      // never-used entries go first, then the LIFO free list
      if (fresh_used < ENTRIES) begin
        e = ADDR_W'(fresh_used);
        fresh_used++;
      end else if (recycle_cnt != 0) begin
        e           = recycle_top;
        recycle_top = cell_link[e];
        recycle_cnt--;
      end else begin
        r.status = ST_FULL;
      end
      if (r.status == ST_OK) begin
        cell_val[e]  = v[DATA_WIDTH-1:0];
        cell_link[e] = '0;
        if (q_live[q]) begin
          cell_link[tail_ptr[q]] = e;
          tail_ptr[q]            = e;
        end else begin
          head_ptr[q] = e;
          tail_ptr[q] = e;
          q_live[q]   = 1'b1;
        end
      end
    end else if (!q_live[q]) begin
      r.status = ST_EMPTY;
    end else begin
      h       = head_ptr[q];
      r.value = VALUE_W'($signed(cell_val[h]));
      // last element: pointers stay stale, only the live flag drops
      if (h == tail_ptr[q]) q_live[q] = 1'b0;
      else                  head_ptr[q] = cell_link[h];
      cell_link[h] = recycle_top;
      recycle_top  = h;
      if (recycle_cnt < ENTRIES) recycle_cnt++;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_QUEUES; k++) begin
        head_ptr[k] = '0;
        tail_ptr[k] = '0;
        q_live[k]   = 1'b0;
      end
      fresh_used   = 0;
      recycle_cnt  = 0;
      recycle_top  = '0;
      owed_responses.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // responses first: a request taken at this edge cannot answer at it
      if (m_valid_i && m_ready_i) begin
        seen.status = m_data_i[STATUS_W-1:0];
        seen.value  = m_data_i[STATUS_W +: VALUE_W];
        if (owed_responses.size() == 0) begin
          $display("%0t: response with none outstanding: status %0d value 0x%08h",
                   $time, seen.status, seen.value);
          fail_count_o++;
        end else begin
          owed = owed_responses.pop_front();
          if (seen.status !== owed.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, owed.status, seen.status);
            fail_count_o++;
          end
          if (seen.value !== owed.value) begin
            $display("%0t: popped_value mismatch: expected 0x%08h, actual 0x%08h",
                     $time, owed.value, seen.value);
            fail_count_o++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        owed_responses.push_back(predict_queue_op(s_data_i[0],
                                                  s_data_i[OPCODE_W +: QSEL_W],
                                                  s_data_i[OPCODE_W + QSEL_W +: VALUE_W]));
      end
      pending_o = owed_responses.size();
    end
  end

endmodule

/* bench/tb.sv */
// Testbench top for the multi-queue linked FIFO: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module tb;
  import mqlf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  multi_queue_linked_fifo DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  mqlf_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // watchdog: too long without any request or response moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // returns at the falling edge after acceptance, valid still high
  task automatic issue_request(input logic [OPCODE_W-1:0] op, input logic [QSEL_W-1:0] q,
                               input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= IN_TDATA_W'({v, q, op});
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_responses();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // bursts with a push-heavy, balanced or pop-heavy mix to fill and drain the store
  task automatic random_phase(input int unsigned n);
    int unsigned       done;
    int unsigned       run;
    int unsigned       push_pct;
    logic [OPCODE_W-1:0] op;
    logic [QSEL_W-1:0]   q;
    done = 0;
    while (done < n) begin
      run = $urandom_range(80, 20);
      case ($urandom_range(3))
        0:       push_pct = 95;
        1:       push_pct = 80;
        2:       push_pct = 50;
        default: push_pct = 15;
      endcase
      for (int i = 0; i < run && done < n; i++) begin
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        if ($urandom_range(11) == 0) q = QSEL_W'($urandom_range(3, NUM_QUEUES));
        else                         q = QSEL_W'($urandom_range(NUM_QUEUES - 1));
        issue_request(op, q, pick_value());
        done++;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pops, bad queue, extreme values, last-element pops
    issue_request(OP_POP,  2'd0, 32'h0);
    issue_request(OP_PUSH, 2'd3, 32'hDEAD_BEEF);
    issue_request(OP_POP,  2'd3, 32'h0);
    issue_request(OP_PUSH, 2'd0, 32'h7FFF_FFFF);
    issue_request(OP_PUSH, 2'd0, 32'h8000_0000);
    issue_request(OP_PUSH, 2'd1, 32'h0000_0000);
    issue_request(OP_PUSH, 2'd1, 32'hFFFF_FFFF);
    issue_request(OP_PUSH, 2'd2, 32'h5555_5555);
    issue_request(OP_PUSH, 2'd2, 32'hAAAA_AAAA);
    issue_request(OP_POP,  2'd0, 32'hFFFF_FFFF);
    issue_request(OP_POP,  2'd0, 32'h0);
    issue_request(OP_POP,  2'd0, 32'h0);
    issue_request(OP_POP,  2'd1, 32'h0);
    issue_request(OP_PUSH, 2'd1, 32'h0000_0001);
    issue_request(OP_POP,  2'd1, 32'h0);
    issue_request(OP_POP,  2'd1, 32'h0);
    issue_request(OP_POP,  2'd2, 32'h0);
    issue_request(OP_POP,  2'd2, 32'h0);
    issue_request(OP_POP,  2'd2, 32'h0);
    issue_request(OP_PUSH, 2'd0, 32'h1234_5678);
    issue_request(OP_POP,  2'd0, 32'h0);
    drain_responses();

    src_idle_pct = 27;
    dst_idle_pct = 76;
    random_phase(650);
    drain_responses();

    src_idle_pct = 76;
    dst_idle_pct = 27;
    random_phase(650);
    drain_responses();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    random_phase(650);
    drain_responses();

    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mqlf_pkg.sv
rtl/core/multi_queue_linked_fifo.sv
bench/mqlf_checker.sv
bench/tb.sv
